[sv/address_watchpoint_table_top_macros.svh]
// Assertion helpers for the watchpoint table.
`ifndef ADDRESS_WATCHPOINT_TABLE_TOP_MACROS_SVH
`define ADDRESS_WATCHPOINT_TABLE_TOP_MACROS_SVH

// Check a property on every rising edge, suspended while reset is held.
`define AWT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define AWT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/awt_pkg.sv]
`default_nettype none
package awt_pkg;

  // Table geometry
  localparam int unsigned WATCH_ENTRIES = 16;
  localparam int unsigned ADDR_W        = 16;
  localparam int unsigned FUNC_W        = 3;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ENABLE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DISABLE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIS_ALL = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CHECK   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd6;

  typedef logic [WATCH_ENTRIES-1:0] entry_vec_t;

  // Request payload
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] watch_addr;
  } awt_req_t;

  // Result payload
  typedef struct packed {
    logic hit;
    logic present;
    logic table_full;
    logic any_enabled;
  } awt_rsp_t;

  // Request register contents handed to the table
  typedef struct packed {
    logic     vld;
    awt_req_t req;
  } awt_stage_t;

endpackage
`default_nettype wire

[sv/address_watchpoint_table_top.sv]
// Channel   Handshake             Payload
// in_       in_valid / in_ready   awt_req_t  (func, watch_addr)
// out_      out_valid / out_ready awt_rsp_t  (hit, present, table_full, any_enabled)
//
// One request per cycle unless out_ready stalls; its result is registered.
// All 16 entries are compared combinationally between request and result registers.
// Synchronous reset clears every valid and enable mark at once; no clearing pass.
// out_ready low holds the result; in_ready falls only when both registers are full
// and out_ready is low.
`default_nettype none
module address_watchpoint_table_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  awt_pkg::awt_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output awt_pkg::awt_rsp_t out_data
);
  import awt_pkg::*;

  awt_stage_t stage;
  awt_rsp_t   rsp;
  logic       adv;
  logic       fire;

  // Request register
  awt_req_reg u_req (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .adv      (adv),
    .stage    (stage)
  );

  // Watchpoint entries and match logic
  awt_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .stage (stage),
    .adv   (adv),
    .fire  (fire),
    .rsp   (rsp)
  );

  // Result register
  awt_rsp_reg u_rsp (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rsp       (rsp),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[sv/awt_req_reg.sv]
`default_nettype none
module awt_req_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  awt_pkg::awt_req_t in_data,
  input  logic              adv,
  output awt_pkg::awt_stage_t stage
);
  import awt_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  awt_req_t req_r;
  logic     take;

  // Accept when empty or when the held request moves on this cycle
  assign in_ready = !vld_r || adv;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hold payload until the next request is taken
  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_data;
    end
  end

  assign stage.vld = vld_r;
  assign stage.req = req_r;

endmodule
`default_nettype wire

[sv/awt_table.sv]
`default_nettype none
module awt_table (
  input  logic                clk,
  input  logic                rst_n,
  input  awt_pkg::awt_stage_t stage,
  input  logic                adv,
  output logic                fire,
  output awt_pkg::awt_rsp_t   rsp
);
  import awt_pkg::*;

  logic [ADDR_W-1:0] addr_r [WATCH_ENTRIES];
  entry_vec_t valid_r;
  entry_vec_t valid_nxt;
  entry_vec_t en_r;
  entry_vec_t en_nxt;
  entry_vec_t match;
  entry_vec_t free_vec;
  entry_vec_t free_oh;
  entry_vec_t wr_oh;
  entry_vec_t post_match;
  logic       any_match;
  logic       tbl_full;
  logic       drop;

  assign fire = stage.vld && adv;

  // Compare every entry with the request address
  always_comb begin
    for (int i = 0; i < WATCH_ENTRIES; i++) begin
      match[i] = valid_r[i] && (addr_r[i] == stage.req.watch_addr);
    end
  end

  assign any_match = |match;
  assign tbl_full  = &valid_r;

  // Pick the lowest free entry as a one-hot vector
  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + entry_vec_t'(1));

  // Work out the table after this request
  always_comb begin
    valid_nxt = valid_r;
    en_nxt    = en_r;
    wr_oh     = '0;
    drop      = 1'b0;
    unique case (stage.req.func)
      FUNC_ADD: begin
        if (any_match) begin
          en_nxt = en_r | match;
        end else if (!tbl_full) begin
          valid_nxt = valid_r | free_oh;
          en_nxt    = en_r | free_oh;
          wr_oh     = free_oh;
        end else begin
          drop = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        valid_nxt = valid_r & ~match;
        en_nxt    = en_r & ~match;
      end
      FUNC_ENABLE:  en_nxt = en_r | match;
      FUNC_DISABLE: en_nxt = en_r & ~match;
      FUNC_DIS_ALL: en_nxt = '0;
      default: ;
    endcase
  end

  // Matched entries keep their address; a fresh entry matches by construction
  assign post_match = (match & valid_nxt) | wr_oh;

  assign rsp.hit         = |(post_match & en_nxt);
  assign rsp.present     = |post_match;
  assign rsp.table_full  = drop;
  assign rsp.any_enabled = |(valid_nxt & en_nxt);

  // Commit marks when the request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      en_r    <= '0;
    end else if (fire) begin
      valid_r <= valid_nxt;
      en_r    <= en_nxt;
    end
  end

  // Write the address of a newly added entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < WATCH_ENTRIES; i++) begin
      if (fire && wr_oh[i]) begin
        addr_r[i] <= stage.req.watch_addr;
      end
    end
  end

endmodule
`default_nettype wire

[sv/awt_rsp_reg.sv]
`default_nettype none
module awt_rsp_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  awt_pkg::awt_rsp_t rsp,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_ready,
  output awt_pkg::awt_rsp_t out_data
);
  import awt_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  awt_rsp_t data_r;

  // Room for a new result when empty or when the held one leaves
  assign adv = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (fire) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (fire) begin
      data_r <= rsp;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

[sv/awt_checker.sv]
`default_nettype none
`include "address_watchpoint_table_top_macros.svh"
module awt_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire awt_pkg::awt_req_t in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire awt_pkg::awt_rsp_t out_data
);
  import awt_pkg::*;

  // Reset empties the result register
  `AWT_ASSERT_ALWAYS(a_rst_empty, clk, (!rst_n |=> !out_valid), "result valid after reset")

  // A stalled result holds
  `AWT_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable(out_data)), "stalled result changed")

  // A hit is always a present, enabled entry
  `AWT_ASSERT(a_hit_present, clk, rst_n, (out_valid && out_data.hit |-> out_data.present && out_data.any_enabled), "hit without present entry")

  // A dropped add leaves the address absent
  `AWT_ASSERT(a_full_absent, clk, rst_n, (out_valid && out_data.table_full |-> !out_data.present && !out_data.hit), "dropped add reports presence")

  // An empty result register always lets a request in
  `AWT_ASSERT(a_ready_empty, clk, rst_n, (!out_valid |-> in_ready), "request refused with empty output")

endmodule

bind address_watchpoint_table_top awt_checker u_awt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
